// ----- sv/glu_pkg.sv -----
// Package for the GCD / LCM unit: datapath widths and sequencer state codes.
// No dependencies; imported by gcd_lcm_unit_core and tb.
`timescale 1ns / 1ps
`default_nettype none

package glu_pkg;

  // Operand and result width
  localparam int unsigned DataW = 64;
  // Step counter and shift count width
  localparam int unsigned CntW  = $clog2(DataW);
  // Packed stream widths
  localparam int unsigned InDataW  = 2 * DataW;
  localparam int unsigned OutDataW = DataW;

  // Operation selector codes
  localparam logic OpGcd = 1'b0;
  localparam logic OpLcm = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StAbsA = 9'b000000010,
    StAbsB = 9'b000000100,
    StChk  = 9'b000001000,
    StGcd  = 9'b000010000,
    StShl  = 9'b000100000,
    StDiv  = 9'b001000000,
    StMul  = 9'b010000000,
    StOut  = 9'b100000000
  } state_e;

endpackage : glu_pkg

`default_nettype wire

// ----- sv/gcd_lcm_unit_core.sv -----
// GCD / LCM unit top level: sequencer around one shared 65-bit adder.
// Depends on glu_pkg (widths, state codes).
`timescale 1ns / 1ps
`default_nettype none

// One item at a time. An accepted item holds two signed 64-bit operands and
// an operation select on s_axis_tuser (0 = gcd, 1 = lcm). Magnitudes are
// taken (the most negative value maps to 2^63 exactly), then the gcd is
// found by binary (Stein) reduction, one shift or subtract-and-shift of the
// shared adder per cycle. For lcm, |a| is divided by the gcd with a
// restoring divider and the quotient is multiplied by |b| with a shift-add
// multiplier; a product above 64 bits returns all ones with the overflow
// flag on m_axis_tuser. After the input transfer each item goes through
// setup (magnitude of a, magnitude of b, zero check), then for nonzero
// operands the reduction loop (common twos plus shifts plus subtracts with
// occasional swaps), then one doubling per common factor of two to restore
// it, then for lcm the divide and the multiply, then the output state and a
// return to idle before the next input transfer. A zero operand skips
// straight to the result. s_axis_tready is high only while idle; the result
// is held until the output transfer completes.
module gcd_lcm_unit_core
  import glu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input stream
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [63:0] first_operand, [127:64] second_operand
  input  wire logic                s_axis_tuser,  // [0] operation
  // Output stream
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,  // [63:0] result_value
  output      logic                m_axis_tuser   // [0] overflow
);

  state_e            state_q, state_d;
  logic [DataW-1:0]  x_q, x_d;     // operand a, then gcd work value
  logic [DataW-1:0]  y_q, y_d;     // operand b, gcd work value, remainder, product
  logic [DataW-1:0]  a_q, a_d;     // |a|, then dividend/quotient shift register
  logic [DataW-1:0]  b_q, b_d;     // |b|, multiplicand
  logic [CntW-1:0]   k_q, k_d;     // common factors of two
  logic [CntW-1:0]   cnt_q, cnt_d; // divide / multiply step counter
  logic              op_q, op_d;
  logic              ovf_q, ovf_d;
  logic [DataW-1:0]  res_q, res_d;
  logic              rovf_q, rovf_d;

  // Shared adder
  logic [DataW-1:0]  add_a, add_b;
  logic              add_ci;
  logic [DataW:0]    sum;

  logic [DataW-1:0]  rem_sh;
  logic              ovf_step;

  logic in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = rovf_q;

  // Partial remainder with the next dividend bit shifted in
  assign rem_sh = {y_q[DataW-2:0], a_q[DataW-1]};

  // Operand select for the shared adder
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (state_q)
      StAbsA: begin
        add_a  = ~x_q;
        add_ci = 1'b1;
      end
      StAbsB: begin
        add_a  = ~y_q;
        add_ci = 1'b1;
      end
      StGcd: begin
        add_a  = x_q;
        add_b  = ~y_q;
        add_ci = 1'b1;
      end
      StDiv: begin
        add_a  = rem_sh;
        add_b  = ~x_q;
        add_ci = 1'b1;
      end
      StMul: begin
        add_a  = {y_q[DataW-2:0], 1'b0};
        add_b  = a_q[DataW-1] ? b_q : '0;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + {{DataW{1'b0}}, add_ci};

  // Product left range when doubling or when adding
  assign ovf_step = y_q[DataW-1] | sum[DataW];

  // Sequencer
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    ovf_d   = ovf_q;
    res_d   = res_q;
    rovf_d  = rovf_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          x_d     = s_axis_tdata[DataW-1:0];
          y_d     = s_axis_tdata[InDataW-1:DataW];
          op_d    = s_axis_tuser;
          k_d     = '0;
          state_d = StAbsA;
        end
      end
      StAbsA: begin
        if (x_q[DataW-1]) x_d = sum[DataW-1:0];
        state_d = StAbsB;
      end
      StAbsB: begin
        if (y_q[DataW-1]) y_d = sum[DataW-1:0];
        state_d = StChk;
      end
      // Zero operands bypass the iteration
      StChk: begin
        a_d = x_q;
        b_d = y_q;
        if (x_q == '0 || y_q == '0) begin
          res_d   = (op_q == OpGcd) ? (x_q | y_q) : '0;
          rovf_d  = 1'b0;
          state_d = StOut;
        end else begin
          state_d = StGcd;
        end
      end
      // Binary gcd step; both values stay nonzero
      StGcd: begin
        if (x_q == y_q) begin
          state_d = StShl;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + CntW'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (sum[DataW]) begin
          x_d = sum[DataW-1:0] >> 1;
        end else begin
          x_d = y_q;
          y_d = x_q;
        end
      end
      // Restore common twos; x then holds the gcd
      StShl: begin
        if (k_q != '0) begin
          x_d = x_q << 1;
          k_d = k_q - CntW'(1);
        end else if (op_q == OpGcd) begin
          res_d   = x_q;
          rovf_d  = 1'b0;
          state_d = StOut;
        end else begin
          y_d     = '0;
          cnt_d   = '1;
          state_d = StDiv;
        end
      end
      // Restoring division |a| / gcd, quotient collects in a
      StDiv: begin
        y_d   = sum[DataW] ? sum[DataW-1:0] : rem_sh;
        a_d   = {a_q[DataW-2:0], sum[DataW]};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          y_d     = '0;
          cnt_d   = '1;
          ovf_d   = 1'b0;
          state_d = StMul;
        end
      end
      // MSB-first shift-add multiply quotient * |b|, sticky overflow
      StMul: begin
        y_d   = sum[DataW-1:0];
        ovf_d = ovf_q | ovf_step;
        a_d   = a_q << 1;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          res_d   = (ovf_q | ovf_step) ? '1 : sum[DataW-1:0];
          rovf_d  = ovf_q | ovf_step;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_xfer) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    a_q    <= a_d;
    b_q    <= b_d;
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    op_q   <= op_d;
    ovf_q  <= ovf_d;
    res_q  <= res_d;
    rovf_q <= rovf_d;
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '1))
    else $error("overflow flagged without saturated result");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (y_q < x_q))
    else $error("divider remainder not below divisor");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StGcd) |-> (x_q != '0 && y_q != '0))
    else $error("gcd iteration reached a zero value");

endmodule : gcd_lcm_unit_core

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for gcd_lcm_unit_core: corner cases, random operand mixes and a long output stall.
// Each result is checked against a local gcd/lcm predictor. Needs glu_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import glu_pkg::*;

  localparam int unsigned HoldCycles  = 1500;   // long receiver hold-off
  localparam int unsigned StallLimit  = 10000;  // cycles without any transfer
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned PrintLimit  = 200;

  localparam logic [DataW-1:0] AllOnes = '1;
  localparam logic [DataW-1:0] MinInt  = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] MaxInt  = {1'b0, {(DataW-1){1'b1}}};

  // One predicted result, with its operands kept for diagnostics
  typedef struct {
    logic             op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] value;
    logic             ovf;
  } gcd_lcm_expect_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [63:0] first_operand, [127:64] second_operand
  logic                s_axis_tuser = 1'b0; // [0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [63:0] result_value
  logic                m_axis_tuser;        // [0] overflow

  gcd_lcm_expect_t pending_results[$];
  int unsigned     error_count   = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  bit              hold_request  = 1'b0;

  gcd_lcm_unit_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Expected gcd or lcm of the operand magnitudes; lcm saturates above 64 bits
  function automatic gcd_lcm_expect_t predict_gcd_lcm(input logic op,
                                                       input logic [DataW-1:0] a,
                                                       input logic [DataW-1:0] b);
    gcd_lcm_expect_t    res;
    logic [DataW-1:0]   mag_a, mag_b, x, y, r, quot;
    logic [2*DataW-1:0] prod;
    res.op    = op;
    res.a     = a;
    res.b     = b;
    res.value = '0;
    res.ovf   = 1'b0;
    // -2^63 maps to 2^63 without loss
    mag_a = a[DataW-1] ? (~a + 1'b1) : a;
    mag_b = b[DataW-1] ? (~b + 1'b1) : b;
    x = mag_a;
    y = mag_b;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    if (op == OpGcd) begin
      res.value = x;
    end else if (mag_a != '0 && mag_b != '0) begin
      quot = mag_a / x;
      prod = {{DataW{1'b0}}, quot} * {{DataW{1'b0}}, mag_b};
      if (prod[2*DataW-1:DataW] != '0) begin
        res.value = AllOnes;
        res.ovf   = 1'b1;
      end else begin
        res.value = prod[DataW-1:0];
      end
    end
    return res;
  endfunction

  // Random value with the given number of low bits live
  function automatic logic [DataW-1:0] rand_bits(input int unsigned width);
    logic [DataW-1:0] v;
    v = {$urandom, $urandom};
    if (width < DataW) v = v & ((64'd1 << width) - 64'd1);
    return v;
  endfunction

  function automatic logic [DataW-1:0] pick_special();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 64'd1;
      2:       return AllOnes;
      3:       return MinInt;
      default: return MaxInt;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input gcd_lcm_expect_t want,
                                 input logic [DataW-1:0] got_value, input logic got_ovf);
    if (error_count < PrintLimit)
      $display("%0t mismatch (%s): op=%0d a=%h b=%h got %h ovf=%0b want %h ovf=%0b",
               $time, what, want.op, want.a, want.b, got_value, got_ovf,
               want.value, want.ovf);
    error_count++;
  endtask

  // Offer one item; returns at the edge where the transfer happens
  task automatic send_item(input logic op, input logic [DataW-1:0] a,
                           input logic [DataW-1:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Zero operands, most negative value, ones, saturation boundary
  task automatic test_corner_cases();
    send_item(OpGcd, '0, '0);
    send_item(OpLcm, '0, '0);
    send_item(OpGcd, '0, -64'd5);
    send_item(OpGcd, 64'd17, '0);
    send_item(OpLcm, '0, 64'd9);
    send_item(OpLcm, MaxInt, '0);
    send_item(OpGcd, MinInt, '0);
    send_item(OpLcm, MinInt, '0);
    send_item(OpGcd, MinInt, MinInt);
    send_item(OpLcm, MinInt, MinInt);
    send_item(OpLcm, MinInt, 64'd1);
    send_item(OpLcm, MinInt, -64'd2);
    send_item(OpLcm, MinInt, 64'd3);
    send_item(OpGcd, AllOnes, 64'd1);
    send_item(OpLcm, AllOnes, AllOnes);
    send_item(OpGcd, MaxInt, MaxInt - 1'b1);
    send_item(OpLcm, MaxInt, MaxInt - 1'b1);
    send_item(OpLcm, MaxInt, MaxInt);
    // 2^64-1 exactly: all ones without the flag
    send_item(OpLcm, 64'hFFFF_FFFF, 64'h1_0000_0001);
    send_item(OpLcm, 64'h1_0000_0000, 64'h1_0000_0001);
    send_item(OpGcd, 64'd12, -64'd18);
    send_item(OpLcm, -64'd6, 64'd4);
    send_item(OpGcd, 64'd1 << 40, 64'd1 << 20);
    send_item(OpLcm, 64'd1 << 40, -(64'd1 << 20));
  endtask

  // Mix of full-width, shared-factor, left-shifted, small, special and one-multiple-of-the-other operands
  task automatic test_random_operands(input int unsigned count);
    logic [DataW-1:0] a, b, g, t;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          a = rand_bits(DataW);
          b = rand_bits(DataW);
        end
        3, 4, 5: begin
          g = rand_bits($urandom_range(1, 32));
          a = g * rand_bits($urandom_range(1, 32));
          b = g * rand_bits($urandom_range(1, 32));
        end
        6: begin
          a = rand_bits(32) << $urandom_range(0, 32);
          b = rand_bits(32) << $urandom_range(0, 32);
        end
        7: begin
          a = rand_bits($urandom_range(1, 20));
          b = rand_bits($urandom_range(1, 20));
        end
        8: begin
          a = pick_special();
          b = rand_bits($urandom_range(1, DataW));
          if ($urandom_range(1) != 0) begin
            t = a;
            a = b;
            b = t;
          end
        end
        default: begin
          a = rand_bits($urandom_range(1, 40));
          b = a * $urandom_range(1, 1000);
        end
      endcase
      if ($urandom_range(1) != 0) a = -a;
      if ($urandom_range(1) != 0) b = -b;
      send_item(($urandom_range(1) != 0) ? OpLcm : OpGcd, a, b);
    end
  endtask

  // Receiver holds off while items keep coming, so the core backs up
  task automatic test_output_stall();
    hold_request = 1'b1;
    for (int unsigned i = 0; i < 6; i++)
      send_item(($urandom_range(1) != 0) ? OpLcm : OpGcd,
                rand_bits($urandom_range(1, DataW)), rand_bits($urandom_range(1, DataW)));
  endtask

  // Output ready: random idling, or a counted hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Predict on input transfers, check on output transfers
  always @(posedge clk_i) begin : result_monitor
    gcd_lcm_expect_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(predict_gcd_lcm(s_axis_tuser, s_axis_tdata[DataW-1:0],
                                                  s_axis_tdata[2*DataW-1:DataW]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          want = '{op: 1'b0, a: '0, b: '0, value: '0, ovf: 1'b0};
          report_mismatch("unexpected result", want, m_axis_tdata, m_axis_tuser);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tuser !== want.ovf)
            report_mismatch("result", want, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("[gcd_lcm_unit_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    // Reset held, then released on a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 72;
    test_corner_cases();
    test_random_operands(330);

    send_idle_pct = 72;
    recv_idle_pct = 12;
    test_random_operands(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random_operands(330);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0)
      $display("[gcd_lcm_unit_core] OK");
    else
      $display("[gcd_lcm_unit_core] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/glu_pkg.sv
sv/gcd_lcm_unit_core.sv
tb/tb.sv
